// File: hw/rtl/pdne_pkg.sv
// ----------------------------------------------------------------------------
// pdne_pkg: shared types and constants for the pedal debounce note engine
// Payload structs, configuration bundle, register codes and fixed codes.
// ----------------------------------------------------------------------------
`default_nettype none

package pdne_pkg;

   // Pedal board size
   localparam int PEDAL_COUNT_DEFAULT = 32;

   // Configuration port geometry
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int REG_IDX_W  = 3;

   // Register indexes
   localparam logic [REG_IDX_W-1:0] REG_KEY_MAP_LOW    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_KEY_MAP_SECOND = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_KEY_MAP_THIRD  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_KEY_MAP_HIGH   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_LOCK_TICKS     = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_NOTE_OFFSET    = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_CHANNEL_NUMBER = 3'd6;

   // Register reset values
   localparam logic [7:0] LOCK_TICKS_RESET  = 8'd50;
   localparam logic [6:0] NOTE_OFFSET_RESET = 7'd24;
   localparam logic [3:0] CHANNEL_RESET     = 4'd1;

   // Message codes
   localparam logic [7:0] UNMAPPED_KEY   = 8'hFF;
   localparam logic [7:0] NOTE_ON_CODE   = 8'h90;
   localparam logic [7:0] NOTE_OFF_CODE  = 8'h80;
   localparam logic [6:0] FIXED_VELOCITY = 7'd64;

   // Input item kinds
   localparam logic MODE_SCAN = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [31:0] raw_pedals;
   } req_type;

   typedef struct packed {
      logic [7:0] status_byte;
      logic [7:0] note_number;
      logic [6:0] velocity;
      logic       note_on;
      logic [4:0] pedal_index;
      logic       last;
   } rsp_type;

   // Classified item handed from front to back
   typedef struct packed {
      logic        is_tick;
      logic [31:0] pedals;
   } item_type;

   typedef struct packed {
      logic [4*64-1:0] key_map;
      logic [7:0]      lock_ticks;
      logic [6:0]      note_offset;
      logic [3:0]      channel_number;
   } cfg_type;

endpackage

`default_nettype wire

// File: hw/rtl/pdne_csr.sv
// ----------------------------------------------------------------------------
// pdne_csr: configuration register file
// APB-style write and read of key maps, lock reload, base note and channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pdne_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pdne_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pdne_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pdne_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output pdne_pkg::cfg_type                cfg
);
   import pdne_pkg::*;

   logic [63:0]          key_low_ff, key_second_ff, key_third_ff, key_high_ff;
   logic [63:0]          key_low_in, key_second_in, key_third_in, key_high_in;
   logic [7:0]           lock_ticks_ff, lock_ticks_in;
   logic [6:0]           note_offset_ff, note_offset_in;
   logic [3:0]           channel_ff, channel_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_beat;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-REG_IDX_W];
   assign wr_beat    = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Decode the write beat
   always_comb begin
      key_low_in     = key_low_ff;
      key_second_in  = key_second_ff;
      key_third_in   = key_third_ff;
      key_high_in    = key_high_ff;
      lock_ticks_in  = lock_ticks_ff;
      note_offset_in = note_offset_ff;
      channel_in     = channel_ff;
      if (wr_beat) begin
         unique case (reg_idx)
            REG_KEY_MAP_LOW:    key_low_in     = csr_pwdata;
            REG_KEY_MAP_SECOND: key_second_in  = csr_pwdata;
            REG_KEY_MAP_THIRD:  key_third_in   = csr_pwdata;
            REG_KEY_MAP_HIGH:   key_high_in    = csr_pwdata;
            REG_LOCK_TICKS:     lock_ticks_in  = csr_pwdata[7:0];
            REG_NOTE_OFFSET:    note_offset_in = csr_pwdata[6:0];
            REG_CHANNEL_NUMBER: channel_in     = csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff     <= '0;
         key_second_ff  <= '0;
         key_third_ff   <= '0;
         key_high_ff    <= '0;
         lock_ticks_ff  <= LOCK_TICKS_RESET;
         note_offset_ff <= NOTE_OFFSET_RESET;
         channel_ff     <= CHANNEL_RESET;
      end else begin
         key_low_ff     <= key_low_in;
         key_second_ff  <= key_second_in;
         key_third_ff   <= key_third_in;
         key_high_ff    <= key_high_in;
         lock_ticks_ff  <= lock_ticks_in;
         note_offset_ff <= note_offset_in;
         channel_ff     <= channel_in;
      end
   end

   // Return the addressed register on a read
   always_comb begin
      unique case (reg_idx)
         REG_KEY_MAP_LOW:    csr_prdata = key_low_ff;
         REG_KEY_MAP_SECOND: csr_prdata = key_second_ff;
         REG_KEY_MAP_THIRD:  csr_prdata = key_third_ff;
         REG_KEY_MAP_HIGH:   csr_prdata = key_high_ff;
         REG_LOCK_TICKS:     csr_prdata = {56'd0, lock_ticks_ff};
         REG_NOTE_OFFSET:    csr_prdata = {57'd0, note_offset_ff};
         REG_CHANNEL_NUMBER: csr_prdata = {60'd0, channel_ff};
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg.key_map        = {key_high_ff, key_third_ff, key_second_ff, key_low_ff};
   assign cfg.lock_ticks     = lock_ticks_ff;
   assign cfg.note_offset    = note_offset_ff;
   assign cfg.channel_number = channel_ff;

endmodule

`default_nettype wire

// File: hw/rtl/pdne_front.sv
// ----------------------------------------------------------------------------
// pdne_front: input side
// Accept items, classify them as tick or scan, and hold them in a
// two-entry queue until the back end takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module pdne_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  pdne_pkg::req_type  req_data,
   output logic               item_valid,
   input  logic               item_take,
   output pdne_pkg::item_type item
);
   import pdne_pkg::*;

   item_type   slot_ff [2];
   item_type   entry;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_beat;
   logic       take_beat;

   assign req_full   = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign push_beat  = req_push & ~req_full;
   assign take_beat  = item_take & item_valid;
   assign item       = slot_ff[rd_ptr_ff];

   // Classify the incoming beat
   always_comb begin
      entry.is_tick = (req_data.mode == MODE_TICK);
      entry.pedals  = entry.is_tick ? 32'd0 : req_data.raw_pedals;
   end

   // Advance queue pointers
   always_comb begin
      wr_ptr_in = push_beat ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take_beat ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_beat} - {1'b0, take_beat};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified item
   always_ff @(posedge clock) begin
      if (push_beat) begin
         slot_ff[wr_ptr_ff] <= entry;
      end
   end

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (req_full && !item_take) |=> req_full)
      else $error("input queue drained without a take");

endmodule

`default_nettype wire

// File: hw/rtl/pdne_back.sv
// ----------------------------------------------------------------------------
// pdne_back: execution side
// Apply ticks to the lock counters, latch a scan's event set, then walk the
// pedals one per cycle into a two-entry result queue, stalling while it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module pdne_back #(
   parameter int PEDAL_COUNT = pdne_pkg::PEDAL_COUNT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   output logic               item_take,
   input  pdne_pkg::item_type item,
   input  pdne_pkg::cfg_type  cfg,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output pdne_pkg::rsp_type  rsp_data
);
   import pdne_pkg::*;

   localparam int IDX_W = $clog2(PEDAL_COUNT);

   logic                   busy_ff, busy_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [PEDAL_COUNT-1:0] pending_ff, pending_in;
   logic [PEDAL_COUNT-1:0] press_ff, press_in;
   logic [PEDAL_COUNT-1:0] prev_ff, prev_in;
   logic [7:0]             lock_ff [PEDAL_COUNT];
   logic [7:0]             lock_in [PEDAL_COUNT];

   logic [PEDAL_COUNT-1:0] locked, mapped, now, changed, pending_clr;
   logic [7:0]             cur_key;
   logic [3:0]             chan_m1;
   logic                   cur_emit, out_space, step, emit;
   rsp_type                event_beat;

   rsp_type    out_slot_ff [2];
   logic       out_wr_ff, out_wr_in;
   logic       out_rd_ff, out_rd_in;
   logic [1:0] out_count_ff, out_count_in;
   logic       pop_beat;

   // Per-pedal lock and map status
   always_comb begin
      for (int i = 0; i < PEDAL_COUNT; i++) begin
         locked[i]      = (lock_ff[i] != 8'd0);
         mapped[i]      = (cfg.key_map[8*i +: 8] != UNMAPPED_KEY);
         pending_clr[i] = pending_ff[i] & (IDX_W'(i) != idx_ff);
      end
      now     = item.pedals[PEDAL_COUNT-1:0] | locked;
      changed = now ^ prev_ff;
   end

   assign item_take = ~busy_ff & item_valid;
   assign cur_emit  = pending_ff[idx_ff];
   assign out_space = (out_count_ff != 2'd2);
   assign step      = busy_ff & (~cur_emit | out_space);
   assign emit      = busy_ff & cur_emit & out_space;
   assign cur_key   = cfg.key_map[{idx_ff, 3'b000} +: 8];
   assign chan_m1   = (cfg.channel_number == 4'd0) ? 4'd0 : cfg.channel_number - 4'd1;

   // Build the event for the current pedal
   always_comb begin
      event_beat.status_byte = (press_ff[idx_ff] ? NOTE_ON_CODE : NOTE_OFF_CODE)
                               | {4'd0, chan_m1};
      event_beat.note_number = {1'b0, cfg.note_offset} + cur_key;
      event_beat.velocity    = FIXED_VELOCITY;
      event_beat.note_on     = press_ff[idx_ff];
      event_beat.pedal_index = 5'(idx_ff);
      event_beat.last        = (pending_clr == '0);
   end

   // Start an item or advance the walk
   always_comb begin
      busy_in    = busy_ff;
      idx_in     = idx_ff;
      pending_in = pending_ff;
      press_in   = press_ff;
      prev_in    = prev_ff;
      lock_in    = lock_ff;
      if (item_take) begin
         if (item.is_tick) begin
            for (int i = 0; i < PEDAL_COUNT; i++) begin
               if (locked[i]) begin
                  lock_in[i] = lock_ff[i] - 8'd1;
               end
            end
         end else begin
            prev_in    = now;
            press_in   = now;
            pending_in = changed & mapped;
            idx_in     = '0;
            busy_in    = |(changed & mapped);
            for (int i = 0; i < PEDAL_COUNT; i++) begin
               if (changed[i] && now[i]) begin
                  lock_in[i] = cfg.lock_ticks;
               end
            end
         end
      end else if (step) begin
         pending_in = pending_clr;
         idx_in     = idx_ff + IDX_W'(1);
         busy_in    = |pending_clr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         idx_ff     <= '0;
         pending_ff <= '0;
         prev_ff    <= '0;
         for (int i = 0; i < PEDAL_COUNT; i++) begin
            lock_ff[i] <= 8'd0;
         end
      end else begin
         busy_ff    <= busy_in;
         idx_ff     <= idx_in;
         pending_ff <= pending_in;
         prev_ff    <= prev_in;
         lock_ff    <= lock_in;
      end
   end

   always_ff @(posedge clock) begin
      press_ff <= press_in;
   end

   // Result queue
   assign rsp_empty = (out_count_ff == 2'd0);
   assign pop_beat  = rsp_pop & ~rsp_empty;
   assign rsp_data  = out_slot_ff[out_rd_ff];

   always_comb begin
      out_wr_in    = emit ? ~out_wr_ff : out_wr_ff;
      out_rd_in    = pop_beat ? ~out_rd_ff : out_rd_ff;
      out_count_in = out_count_ff + {1'b0, emit} - {1'b0, pop_beat};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= 1'b0;
         out_rd_ff    <= 1'b0;
         out_count_ff <= 2'd0;
      end else begin
         out_wr_ff    <= out_wr_in;
         out_rd_ff    <= out_rd_in;
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_slot_ff[out_wr_ff] <= event_beat;
      end
   end

   a_busy_pending: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pending_ff != '0))
      else $error("walk running with no pending events");

   a_tick_no_walk: assert property (@(posedge clock) disable iff (reset)
      (item_take && item.is_tick) |=> !busy_ff)
      else $error("tick started a walk");

   a_last_ends_walk: assert property (@(posedge clock) disable iff (reset)
      (emit && event_beat.last) |=> !busy_ff)
      else $error("walk continued after final event");

endmodule

`default_nettype wire

// File: hw/rtl/pedal_debounce_note_events_top.sv
// ----------------------------------------------------------------------------
// pedal_debounce_note_events_top: pedal board debounce and note event engine
// Front queue, back walker and configuration registers.
// ----------------------------------------------------------------------------
// A tick is applied to the lock counters when taken and starts no walk. A scan
// latches its event set, then walks the pedals one per cycle, stalling while
// the result queue is full, up to the highest pedal with an event; no new item
// is taken until the walk ends.
// Synchronous reset clears both queues, the previous pedal state and all lock
// counters, and returns the registers to their default values.
`default_nettype none

module pedal_debounce_note_events_top #(
   parameter int PEDAL_COUNT = pdne_pkg::PEDAL_COUNT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  pdne_pkg::req_type               req_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output pdne_pkg::rsp_type               rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pdne_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pdne_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pdne_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import pdne_pkg::*;

   cfg_type  cfg;
   item_type item;
   logic     item_valid;
   logic     item_take;

   pdne_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pdne_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item)
   );

   pdne_back #(
      .PEDAL_COUNT (PEDAL_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item),
      .cfg        (cfg),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
